// ===== src/f12seq_pkg.sv =====
// Shared types and constants of the FAT12 cluster chain sector sequencer.
package f12seq_pkg;

	// Widths fixed by the item fields.
	localparam int unsigned TADDR_W   = 13;
	localparam int unsigned CLUSTER_W = 12;
	localparam int unsigned SECTOR_W  = 32;
	localparam int unsigned SPC_W     = 8;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned PROD_W    = CLUSTER_W + 1 + SPC_W + 1;

	// Cluster values at or above this mark the end of a chain.
	localparam logic [CLUSTER_W-1:0] END_MARK = 12'hFF8;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_DATA_START = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_SPC        = 1'b1;

	typedef enum logic [1:0] {
		OP_LOAD    = 2'd0,
		OP_OPEN    = 2'd1,
		OP_ADVANCE = 2'd2
	} op_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RD_LO,
		S_RD_HI,
		S_MERGE,
		S_MUL,
		S_ADD_BASE,
		S_ADD_OFS,
		S_ROOT_INC,
		S_RESP
	} state_t;

	// Access to the allocation table store.
	typedef struct packed {
		logic               wr_en;
		logic [TADDR_W-1:0] wr_addr;
		logic [7:0]         wr_data;
		logic [TADDR_W-1:0] rd_addr;
	} tbl_req_t;

endpackage

// ===== src/f12seq_cmd_if.sv =====
// Command channel carrying one operation item into the sequencer.
interface f12seq_cmd_if;
	logic                              valid;
	logic                              ready;
	logic [1:0]                        opcode;
	logic [f12seq_pkg::TADDR_W-1:0]    table_address;
	logic [7:0]                        table_byte;
	logic [f12seq_pkg::CLUSTER_W-1:0]  start_cluster;
	logic [f12seq_pkg::SECTOR_W-1:0]   start_sector;
	logic                              linear_mode;

	modport source (
		output valid, opcode, table_address, table_byte, start_cluster, start_sector,
			linear_mode,
		input  ready
	);
	modport sink (
		input  valid, opcode, table_address, table_byte, start_cluster, start_sector,
			linear_mode,
		output ready
	);
endinterface

// ===== src/f12seq_rsp_if.sv =====
// Response channel carrying one result item out of the sequencer.
interface f12seq_rsp_if;
	logic                              valid;
	logic                              ready;
	logic [f12seq_pkg::SECTOR_W-1:0]   sector_address;
	logic [f12seq_pkg::CLUSTER_W-1:0]  current_cluster_out;
	logic                              sector_valid;
	logic                              chain_end;

	modport source (
		output valid, sector_address, current_cluster_out, sector_valid, chain_end,
		input  ready
	);
	modport sink (
		input  valid, sector_address, current_cluster_out, sector_valid, chain_end,
		output ready
	);
endinterface

// ===== src/f12seq_cfg_if.sv =====
// Configuration write channel: register index and write data.
interface f12seq_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [f12seq_pkg::CFG_IDX_W-1:0]  index;
	logic [f12seq_pkg::SECTOR_W-1:0]   data;

	modport source (
		output valid, index, data,
		input  ready
	);
	modport sink (
		input  valid, index, data,
		output ready
	);
endinterface

// ===== src/fat12_chain_sector_sequencer_core.sv =====
// Top level of the FAT12 cluster chain sector sequencer.
// The block holds a FAT12 allocation table that is filled with load items and walks one
// file's cluster chain, answering every item with exactly one result item. It takes one
// item at a time: cmd.ready is high only while no item is in work, and the result waits
// in its register until rsp takes it. A load, a reserved code, a root-mode open, an
// advance after the chain has ended, or an advance inside a cluster that stands on an end
// marker goes straight to the result; a root-mode advance first steps the sector address;
// a chain open or an advance inside a cluster runs the cluster offset multiply and then
// the two adds; an advance that crosses into the next cluster first reads the entry's two
// bytes and merges them, and then answers at once if the next cluster is an end marker or
// else goes on to the multiply and the two adds. The next item can be taken in the cycle
// after the result is taken. The table store has a single read port, which gives one byte
// per cycle so that a table entry costs two reads, and one shared 32-bit adder forms the
// sector address in two steps after the multiply. There is no clearing pass: table entries
// must be loaded before the walk reads them.
module fat12_chain_sector_sequencer_core #(
	parameter int unsigned TABLE_BYTES = 8192
) (
	input  logic              clk,
	input  logic              arst_n,
	f12seq_cmd_if.sink        cmd,
	f12seq_rsp_if.source      rsp,
	f12seq_cfg_if.sink        cfg
);

	localparam int unsigned CW = f12seq_pkg::CLUSTER_W;
	localparam int unsigned SW = f12seq_pkg::SECTOR_W;
	localparam int unsigned AW = f12seq_pkg::TADDR_W;
	localparam int unsigned PW = f12seq_pkg::PROD_W;

	f12seq_pkg::state_t         state_q;
	f12seq_pkg::state_t         state_d;
	f12seq_pkg::tbl_req_t       tbl_req;

	logic [SW-1:0]              data_start_q;
	logic [f12seq_pkg::SPC_W-1:0] spc_q;
	logic [SW-1:0]              walk_q;
	logic [f12seq_pkg::SPC_W-1:0] sic_q;
	logic                       root_q;
	logic                       ended_q;
	logic                       res_valid_q;
	logic [SW-1:0]              acc_q;
	logic signed [PW-1:0]       prod_q;
	logic [7:0]                 lo_q;

	logic                       cmd_fire;
	logic                       cfg_fire;
	logic [7:0]                 rd_byte;
	logic [AW-1:0]              entry_idx;
	logic [f12seq_pkg::SPC_W-1:0] sic_inc;
	logic                       crosses;
	logic                       walk_at_end;
	logic [15:0]                entry_word;
	logic [CW-1:0]              next_cluster;
	logic [CW:0]                cluster_m2;
	logic [SW-1:0]              add_a;
	logic [SW-1:0]              add_b;
	logic [SW-1:0]              add_sum;

	assign cmd_fire = cmd.valid && cmd.ready;
	assign cfg_fire = cfg.valid && cfg.ready;
	assign cmd.ready = (state_q == f12seq_pkg::S_IDLE);
	assign cfg.ready = 1'b1;

	// Table entry location: byte index cluster * 3 / 2.
	assign entry_idx = AW'({1'b0, walk_q[CW-1:0]}) + AW'(walk_q[CW-1:1]);

	// Sector position step and end check on the current cluster.
	assign sic_inc     = sic_q + 1'b1;
	assign crosses     = sic_inc >= spc_q;
	assign walk_at_end = walk_q >= SW'(f12seq_pkg::END_MARK);

	// The twelve-bit entry sits low in the word for an even cluster, high for an odd one.
	assign entry_word   = {rd_byte, lo_q};
	assign next_cluster = walk_q[0] ? entry_word[15:4] : entry_word[CW-1:0];
	assign cluster_m2   = {1'b0, walk_q[CW-1:0]} - (CW + 1)'(2);

	// Table store access.
	always_comb begin
		tbl_req.wr_en   = cmd_fire && (f12seq_pkg::op_t'(cmd.opcode) == f12seq_pkg::OP_LOAD);
		tbl_req.wr_addr = cmd.table_address;
		tbl_req.wr_data = cmd.table_byte;
		tbl_req.rd_addr = (state_q == f12seq_pkg::S_RD_HI) ? entry_idx + 1'b1 : entry_idx;
	end

	f12seq_table #(
		.TABLE_BYTES(TABLE_BYTES)
	) u_table (
		.clk     (clk),
		.req     (tbl_req),
		.rd_byte (rd_byte)
	);

	// Shared address adder, its operands chosen by the sequencer step.
	always_comb begin
		case (state_q)
			f12seq_pkg::S_ADD_BASE: begin
				add_a = data_start_q;
				add_b = SW'(prod_q);
			end
			f12seq_pkg::S_ADD_OFS: begin
				add_a = acc_q;
				add_b = SW'(sic_q);
			end
			f12seq_pkg::S_ROOT_INC: begin
				add_a = walk_q;
				add_b = SW'(1);
			end
			default: begin
				add_a = acc_q;
				add_b = '0;
			end
		endcase
	end
	assign add_sum = add_a + add_b;

	// Next state of the sequencer.
	always_comb begin
		state_d = state_q;
		case (state_q)
			f12seq_pkg::S_IDLE: begin
				if (cmd_fire) begin
					case (f12seq_pkg::op_t'(cmd.opcode))
						f12seq_pkg::OP_OPEN: begin
							state_d = cmd.linear_mode ? f12seq_pkg::S_RESP : f12seq_pkg::S_MUL;
						end
						f12seq_pkg::OP_ADVANCE: begin
							if (ended_q) begin
								state_d = f12seq_pkg::S_RESP;
							end else if (root_q) begin
								state_d = f12seq_pkg::S_ROOT_INC;
							end else if (crosses) begin
								state_d = f12seq_pkg::S_RD_LO;
							end else if (walk_at_end) begin
								state_d = f12seq_pkg::S_RESP;
							end else begin
								state_d = f12seq_pkg::S_MUL;
							end
						end
						default: state_d = f12seq_pkg::S_RESP;
					endcase
				end
			end
			f12seq_pkg::S_RD_LO:    state_d = f12seq_pkg::S_RD_HI;
			f12seq_pkg::S_RD_HI:    state_d = f12seq_pkg::S_MERGE;
			f12seq_pkg::S_MERGE: begin
				state_d = (next_cluster >= f12seq_pkg::END_MARK) ? f12seq_pkg::S_RESP
					: f12seq_pkg::S_MUL;
			end
			f12seq_pkg::S_MUL:      state_d = f12seq_pkg::S_ADD_BASE;
			f12seq_pkg::S_ADD_BASE: state_d = f12seq_pkg::S_ADD_OFS;
			f12seq_pkg::S_ADD_OFS:  state_d = f12seq_pkg::S_RESP;
			f12seq_pkg::S_ROOT_INC: state_d = f12seq_pkg::S_RESP;
			f12seq_pkg::S_RESP: begin
				if (rsp.ready) begin
					state_d = f12seq_pkg::S_IDLE;
				end
			end
			default: state_d = f12seq_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= f12seq_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_start_q <= '0;
			spc_q        <= f12seq_pkg::SPC_W'(1);
		end else if (cfg_fire) begin
			case (cfg.index)
				f12seq_pkg::CFG_DATA_START: data_start_q <= cfg.data;
				f12seq_pkg::CFG_SPC:        spc_q <= cfg.data[f12seq_pkg::SPC_W-1:0];
				default: ;
			endcase
		end
	end

	// Walk state and result flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_q      <= '0;
			sic_q       <= '0;
			root_q      <= 1'b0;
			ended_q     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			case (state_q)
				f12seq_pkg::S_IDLE: begin
					if (cmd_fire) begin
						case (f12seq_pkg::op_t'(cmd.opcode))
							f12seq_pkg::OP_OPEN: begin
								ended_q <= 1'b0;
								sic_q   <= '0;
								root_q  <= cmd.linear_mode;
								if (cmd.linear_mode) begin
									walk_q      <= cmd.start_sector;
									res_valid_q <= 1'b1;
								end else begin
									walk_q <= SW'(cmd.start_cluster);
								end
							end
							f12seq_pkg::OP_ADVANCE: begin
								if (ended_q) begin
									res_valid_q <= 1'b0;
								end else if (!root_q) begin
									if (crosses) begin
										sic_q <= '0;
									end else begin
										sic_q <= sic_inc;
										if (walk_at_end) begin
											ended_q     <= 1'b1;
											res_valid_q <= 1'b0;
										end
									end
								end
							end
							default: res_valid_q <= 1'b0;
						endcase
					end
				end
				f12seq_pkg::S_MERGE: begin
					walk_q <= SW'(next_cluster);
					if (next_cluster >= f12seq_pkg::END_MARK) begin
						ended_q     <= 1'b1;
						res_valid_q <= 1'b0;
					end
				end
				f12seq_pkg::S_ADD_OFS: res_valid_q <= 1'b1;
				f12seq_pkg::S_ROOT_INC: begin
					walk_q      <= add_sum;
					res_valid_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// Datapath registers: table byte, offset product and sector accumulator.
	always_ff @(posedge clk) begin
		if (state_q == f12seq_pkg::S_RD_HI) begin
			lo_q <= rd_byte;
		end
		if (state_q == f12seq_pkg::S_MUL) begin
			prod_q <= $signed(cluster_m2) * $signed({1'b0, spc_q});
		end
		if (cmd_fire) begin
			acc_q <= cmd.start_sector;
		end else if (state_q == f12seq_pkg::S_ADD_BASE || state_q == f12seq_pkg::S_ADD_OFS
			|| state_q == f12seq_pkg::S_ROOT_INC) begin
			acc_q <= add_sum;
		end
	end

	// Result item.
	assign rsp.valid               = (state_q == f12seq_pkg::S_RESP);
	assign rsp.sector_address      = res_valid_q ? acc_q : '0;
	assign rsp.current_cluster_out = root_q ? '0 : walk_q[CW-1:0];
	assign rsp.sector_valid        = res_valid_q;
	assign rsp.chain_end           = ended_q;

	// A result never names a sector and the end of the chain together.
	a_valid_excl_end: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !(rsp.sector_valid && rsp.chain_end))
		else $error("result shows a sector and chain end together");

	// An accepted item keeps the block busy in the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_fire |=> !cmd.ready)
		else $error("block ready right after accepting an item");

	// Once a result is taken the block is ready for the next item.
	a_ready_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.ready) |=> (cmd.ready && !rsp.valid))
		else $error("block not ready after result was taken");

	// Root mode walks report no cluster.
	a_root_no_cluster: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && root_q) |-> (rsp.current_cluster_out == '0))
		else $error("root mode result shows a cluster");

endmodule

// ===== src/f12seq_table.sv =====
// Allocation table byte store with one write and one registered read port.
module f12seq_table #(
	parameter int unsigned TABLE_BYTES = 8192
) (
	input  logic                  clk,
	input  f12seq_pkg::tbl_req_t  req,
	output logic [7:0]            rd_byte
);

	localparam int unsigned AW = $clog2(TABLE_BYTES);
	localparam logic [f12seq_pkg::TADDR_W:0] LIMIT = (f12seq_pkg::TADDR_W + 1)'(TABLE_BYTES);

	logic [7:0] mem [TABLE_BYTES];
	logic [7:0] rdata_q;
	logic       rd_ok_q;
	logic       wr_in_range;
	logic       rd_in_range;

	// Addresses past the end of the store are ignored on write and read as zero.
	assign wr_in_range = {1'b0, req.wr_addr} < LIMIT;
	assign rd_in_range = {1'b0, req.rd_addr} < LIMIT;

	// Store write and registered read.
	always_ff @(posedge clk) begin
		if (req.wr_en && wr_in_range) begin
			mem[req.wr_addr[AW-1:0]] <= req.wr_data;
		end
		rdata_q <= mem[req.rd_addr[AW-1:0]];
		rd_ok_q <= rd_in_range;
	end

	assign rd_byte = rd_ok_q ? rdata_q : 8'd0;

endmodule

// ===== bench/tb_top.sv =====
// Testbench for the FAT12 cluster chain sector sequencer: random chain walks checked by a scoreboard.
`timescale 1ns / 1ps

module tb_top;

	localparam int unsigned TBL_BYTES    = 8192;
	localparam logic [1:0]  OP_RESERVED  = 2'd3;
	localparam int unsigned PHASE_ITEMS  = 270;
	localparam int unsigned HOLD_CYCLES  = 300;
	localparam int unsigned HOLD_AFTER   = 400;
	localparam int unsigned SETTLE_CYCLES = 12;

	// One command item as it goes onto the command channel.
	typedef struct packed {
		logic [1:0]                       opcode;
		logic [f12seq_pkg::TADDR_W-1:0]   taddr;
		logic [7:0]                       tbyte;
		logic [f12seq_pkg::CLUSTER_W-1:0] sclus;
		logic [f12seq_pkg::SECTOR_W-1:0]  ssec;
		logic                             lin;
	} cmd_item_t;

	// One result item as the sequencer answers it.
	typedef struct packed {
		logic [f12seq_pkg::SECTOR_W-1:0]  sector;
		logic [f12seq_pkg::CLUSTER_W-1:0] cluster;
		logic                             sec_valid;
		logic                             ended;
	} sector_result_t;

	// Keeps a shadow of the table and of the walk, and the queue of expected sectors.
	class chain_scoreboard;
		logic [7:0]          fat_bytes [TBL_BYTES];
		bit                  loaded [TBL_BYTES];
		logic [31:0]         walk_pos;
		logic [7:0]          sec_in_clus;
		bit                  root_walk;
		bit                  chain_done;
		logic [31:0]         data_start;
		logic [7:0]          spc;
		sector_result_t      sector_q[$];
		int unsigned         errors;

		function new();
			walk_pos = 0;
			sec_in_clus = 0;
			root_walk = 0;
			chain_done = 0;
			data_start = 0;
			spc = 8'd1;
			errors = 0;
			foreach (loaded[i]) loaded[i] = 0;
		endfunction

		function void write_reg(logic [f12seq_pkg::CFG_IDX_W-1:0] idx, logic [31:0] value);
			if (idx == f12seq_pkg::CFG_DATA_START)
				data_start = value;
			else if (idx == f12seq_pkg::CFG_SPC)
				spc = value[7:0];
		endfunction

		// Sector address of a cluster plus an offset, wrapping at 32 bits.
		function logic [31:0] cluster_lba(logic [31:0] clus, logic [7:0] ofs);
			logic [31:0] lba;
			lba = data_start + (clus - 32'd2) * {24'd0, spc} + {24'd0, ofs};
			return lba;
		endfunction

		// The 12-bit table entry of a cluster.
		function logic [31:0] fat_entry(logic [31:0] clus);
			int unsigned idx;
			logic [15:0] word;
			idx = (clus * 32'd3) / 32'd2;
			word = {fat_bytes[idx + 1], fat_bytes[idx]};
			return clus[0] ? {20'd0, word[15:4]} : {20'd0, word[11:0]};
		endfunction

		function void push_result(logic [31:0] sector, bit valid);
			sector_result_t r;
			r.sector = valid ? sector : 32'd0;
			r.cluster = root_walk ? 12'd0 : walk_pos[11:0];
			r.sec_valid = valid;
			r.ended = chain_done;
			sector_q.push_back(r);
		endfunction

		// Tells whether the next advance crosses into a new cluster and so reads the table.
		function bit fetch_pending(output int unsigned idx);
			logic [7:0] nxt;
			nxt = sec_in_clus + 8'd1;
			idx = 0;
			if (chain_done || root_walk || nxt < spc)
				return 0;
			idx = (walk_pos * 32'd3) / 32'd2;
			return 1;
		endfunction

		function void note_cmd(cmd_item_t it);
			if (it.opcode == f12seq_pkg::OP_OPEN) begin
				chain_done = 0;
				sec_in_clus = 0;
				if (it.lin) begin
					root_walk = 1;
					walk_pos = it.ssec;
					push_result(walk_pos, 1);
				end else begin
					root_walk = 0;
					walk_pos = {20'd0, it.sclus};
					push_result(cluster_lba(walk_pos, 8'd0), 1);
				end
			end else if (it.opcode == f12seq_pkg::OP_ADVANCE) begin
				if (chain_done) begin
					push_result(32'd0, 0);
				end else if (root_walk) begin
					walk_pos = walk_pos + 32'd1;
					push_result(walk_pos, 1);
				end else begin
					sec_in_clus = sec_in_clus + 8'd1;
					if (sec_in_clus >= spc) begin
						sec_in_clus = 0;
						walk_pos = fat_entry(walk_pos);
					end
					if (walk_pos >= {20'd0, f12seq_pkg::END_MARK}) begin
						chain_done = 1;
						push_result(32'd0, 0);
					end else begin
						push_result(cluster_lba(walk_pos, sec_in_clus), 1);
					end
				end
			end else begin
				// Loads write the table; the reserved code only answers.
				if (it.opcode == f12seq_pkg::OP_LOAD && int'(it.taddr) < TBL_BYTES) begin
					fat_bytes[it.taddr] = it.tbyte;
					loaded[it.taddr] = 1;
				end
				push_result(32'd0, 0);
			end
		endfunction

		function void check_rsp(sector_result_t got);
			sector_result_t want;
			if (sector_q.size() == 0) begin
				$error("result with nothing expected: sector_address %h", got.sector);
				errors++;
				return;
			end
			want = sector_q.pop_front();
			if (got.sector !== want.sector) begin
				$error("sector_address: expected %h, got %h", want.sector, got.sector);
				errors++;
			end
			if (got.cluster !== want.cluster) begin
				$error("current_cluster_out: expected %h, got %h", want.cluster, got.cluster);
				errors++;
			end
			if (got.sec_valid !== want.sec_valid) begin
				$error("sector_valid: expected %b, got %b", want.sec_valid, got.sec_valid);
				errors++;
			end
			if (got.ended !== want.ended) begin
				$error("chain_end: expected %b, got %b", want.ended, got.ended);
				errors++;
			end
		endfunction

		function int unsigned pending();
			return sector_q.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	f12seq_cmd_if cmd_ch();
	f12seq_rsp_if rsp_ch();
	f12seq_cfg_if cfg_ch();

	fat12_chain_sector_sequencer_core #(
		.TABLE_BYTES(TBL_BYTES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch),
		.rsp(rsp_ch),
		.cfg(cfg_ch)
	);

	chain_scoreboard sb = new();

	int unsigned burst_left = 0;
	int unsigned items_sent = 0;
	int unsigned rsp_seen = 0;

	always #1 clk = ~clk;

	// Run limit far above the slowest correct run.
	initial begin
		#2000000;
		$display("FAIL fat12_chain_sector_sequencer_core");
		$finish;
	end

	// Result monitor: every accepted result is checked against the oldest expectation.
	initial begin
		sector_result_t got;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
				got.sector = rsp_ch.sector_address;
				got.cluster = rsp_ch.current_cluster_out;
				got.sec_valid = rsp_ch.sector_valid;
				got.ended = rsp_ch.chain_end;
				sb.check_rsp(got);
				rsp_seen++;
			end
		end
	end

	// Result side stalls on its own pattern, with one long hold-off partway through.
	initial begin
		int unsigned cyc;
		int unsigned mode;
		int unsigned hold_left;
		bit hold_done;
		cyc = 0;
		mode = 0;
		hold_left = 0;
		hold_done = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			cyc++;
			if (cyc % 64 == 0)
				mode = $urandom_range(0, 3);
			if (hold_left > 0) begin
				rsp_ch.ready = 1'b0;
				hold_left--;
			end else if (!hold_done && rsp_seen >= HOLD_AFTER) begin
				hold_done = 1;
				hold_left = HOLD_CYCLES - 1;
				rsp_ch.ready = 1'b0;
			end else begin
				case (mode)
					0: rsp_ch.ready = 1'b1;
					1: rsp_ch.ready = ($urandom_range(0, 3) != 0);
					2: rsp_ch.ready = (cyc % 3 != 0);
					default: rsp_ch.ready = ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// Drives one item; entered and left at a falling edge, valid stays high inside a burst.
	task automatic send_cmd(input cmd_item_t it);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				cmd_ch.valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		burst_left--;
		cmd_ch.opcode = it.opcode;
		cmd_ch.table_address = it.taddr;
		cmd_ch.table_byte = it.tbyte;
		cmd_ch.start_cluster = it.sclus;
		cmd_ch.start_sector = it.ssec;
		cmd_ch.linear_mode = it.lin;
		cmd_ch.valid = 1'b1;
		do @(posedge clk); while (!cmd_ch.ready);
		sb.note_cmd(it);
		items_sent++;
		@(negedge clk);
	endtask

	// Fields an operation does not use still carry random values.
	function automatic cmd_item_t rand_item(logic [1:0] op);
		cmd_item_t it;
		it.opcode = op;
		it.taddr = f12seq_pkg::TADDR_W'($urandom);
		it.tbyte = 8'($urandom);
		it.sclus = f12seq_pkg::CLUSTER_W'($urandom);
		it.ssec = $urandom;
		it.lin = 1'($urandom);
		return it;
	endfunction

	task automatic do_load(input int unsigned addr, input logic [7:0] value);
		cmd_item_t it;
		it = rand_item(f12seq_pkg::OP_LOAD);
		it.taddr = f12seq_pkg::TADDR_W'(addr);
		it.tbyte = value;
		send_cmd(it);
	endtask

	task automatic do_open_chain(input logic [f12seq_pkg::CLUSTER_W-1:0] clus);
		cmd_item_t it;
		it = rand_item(f12seq_pkg::OP_OPEN);
		it.sclus = clus;
		it.lin = 1'b0;
		send_cmd(it);
	endtask

	task automatic do_open_root(input logic [31:0] sector);
		cmd_item_t it;
		it = rand_item(f12seq_pkg::OP_OPEN);
		it.ssec = sector;
		it.lin = 1'b1;
		send_cmd(it);
	endtask

	// An advance that would read table bytes never loaded gets them loaded first.
	task automatic do_advance();
		int unsigned idx;
		if (sb.fetch_pending(idx)) begin
			if (!sb.loaded[idx])
				do_load(idx, 8'($urandom));
			if (!sb.loaded[idx + 1])
				do_load(idx + 1, 8'($urandom));
		end
		send_cmd(rand_item(f12seq_pkg::OP_ADVANCE));
	endtask

	task automatic do_reserved();
		send_cmd(rand_item(OP_RESERVED));
	endtask

	// Writes one 12-bit entry, keeping the neighbor's nibble in the shared byte.
	task automatic set_fat_entry(input int unsigned clus, input logic [11:0] value);
		int unsigned idx;
		logic [15:0] word;
		idx = (clus * 3) / 2;
		word[7:0] = sb.loaded[idx] ? sb.fat_bytes[idx] : 8'($urandom);
		word[15:8] = sb.loaded[idx + 1] ? sb.fat_bytes[idx + 1] : 8'($urandom);
		if (clus % 2 == 1)
			word = {value, word[3:0]};
		else
			word = {word[15:12], value};
		do_load(idx, word[7:0]);
		do_load(idx + 1, word[15:8]);
	endtask

	task automatic write_reg(input logic [f12seq_pkg::CFG_IDX_W-1:0] idx,
		input logic [31:0] value);
		cfg_ch.index = idx;
		cfg_ch.data = value;
		cfg_ch.valid = 1'b1;
		do @(posedge clk); while (!cfg_ch.ready);
		sb.write_reg(idx, value);
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	// Stops offering items and waits until every expected result is in and the block settles.
	task automatic drain();
		cmd_ch.valid = 1'b0;
		burst_left = 0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Builds a well-formed chain in the table, opens it and walks it, mostly to its end.
	task automatic walk_file();
		logic [11:0] clus [6];
		int unsigned len;
		int unsigned span;
		int unsigned steps;
		len = (sb.spc >= 8'd16) ? $urandom_range(1, 2) : $urandom_range(1, 5);
		for (int k = 0; k < len; k++)
			clus[k] = 12'($urandom_range(2, int'(f12seq_pkg::END_MARK) - 1));
		for (int k = 0; k < len; k++)
			set_fat_entry(clus[k], (k == len - 1) ?
				12'($urandom_range(int'(f12seq_pkg::END_MARK), 12'hFFF)) : clus[k + 1]);
		do_open_chain(clus[0]);
		span = len * sb.spc;
		steps = ($urandom_range(0, 3) != 0) ? span + $urandom_range(0, 2)
			: $urandom_range(0, span);
		repeat (steps) do_advance();
	endtask

	// One random stretch of stimulus: mostly chain walks, the rest root walks and noise.
	task automatic random_step();
		int unsigned pick;
		logic [31:0] start;
		pick = $urandom_range(0, 99);
		if (pick < 55) begin
			walk_file();
		end else if (pick < 70) begin
			start = ($urandom_range(0, 4) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 6)
				: $urandom;
			do_open_root(start);
			repeat ($urandom_range(0, 12)) do_advance();
		end else if (pick < 80) begin
			repeat ($urandom_range(1, 4)) do_load($urandom_range(0, TBL_BYTES - 1),
				8'($urandom));
		end else if (pick < 88) begin
			repeat ($urandom_range(1, 5)) do_advance();
		end else if (pick < 94) begin
			do_open_chain(12'($urandom));
			repeat ($urandom_range(0, 3)) do_advance();
		end else begin
			do_reserved();
		end
	endtask

	// Main sequence: reset, directed cases, then random phases under several settings.
	initial begin
		int unsigned phase_start;
		logic [31:0] ds;
		logic [7:0] spc;
		cmd_ch.valid = 1'b0;
		cmd_ch.opcode = f12seq_pkg::OP_LOAD;
		cmd_ch.table_address = '0;
		cmd_ch.table_byte = '0;
		cmd_ch.start_cluster = '0;
		cmd_ch.start_sector = '0;
		cmd_ch.linear_mode = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = f12seq_pkg::CFG_DATA_START;
		cfg_ch.data = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		write_reg(f12seq_pkg::CFG_DATA_START, 32'h0000_0100);
		write_reg(f12seq_pkg::CFG_SPC, 32'd1);

		// Reserved code, then a walk from cluster zero before any open, past its end.
		do_reserved();
		set_fat_entry(0, 12'h003);
		set_fat_entry(3, 12'hFFF);
		do_advance();
		do_advance();
		do_advance();
		// Loads at the extremes of address and data.
		do_load(13'h1FFF, 8'hFF);
		do_load(13'h0AAA, 8'h55);
		// Open at an end marker, then at clusters zero and one.
		set_fat_entry(12'hFFF, f12seq_pkg::END_MARK);
		do_open_chain(12'hFFF);
		do_advance();
		do_open_chain(12'h000);
		do_open_chain(12'h001);
		do_advance();
		// Root walks, one wrapping past the top of the sector space.
		do_open_root(32'hFFFF_FFFE);
		do_advance();
		do_advance();
		do_open_root(32'h0000_0000);
		do_advance();
		drain();

		for (int p = 0; p < 6; p++) begin
			case (p)
				0: begin ds = 32'd0; spc = 8'd1; end
				1: begin ds = 32'hFFFF_FFFF; spc = 8'd128; end
				2: begin ds = $urandom; spc = 8'($urandom_range(2, 8)); end
				3: begin ds = $urandom; spc = 8'($urandom_range(1, 128)); end
				4: begin ds = $urandom_range(0, 4096); spc = 8'd3; end
				default: begin ds = $urandom; spc = 8'd1; end
			endcase
			write_reg(f12seq_pkg::CFG_DATA_START, ds);
			write_reg(f12seq_pkg::CFG_SPC, {24'd0, spc});
			phase_start = items_sent;
			while (items_sent - phase_start < PHASE_ITEMS)
				random_step();
			drain();
		end

		if (sb.errors == 0 && sb.pending() == 0)
			$display("PASS fat12_chain_sector_sequencer_core");
		else
			$display("FAIL fat12_chain_sector_sequencer_core");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/f12seq_pkg.sv
src/f12seq_cmd_if.sv
src/f12seq_rsp_if.sv
src/f12seq_cfg_if.sv
src/f12seq_table.sv
src/fat12_chain_sector_sequencer_core.sv
bench/tb_top.sv
